// ----- hdl/byte_double_ended_queue_core_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the byte deque core
// Both macros expect clk and rst to be visible at the point of use.
// ---------------------------------------------------------------------------
`ifndef BYTE_DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define BYTE_DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked outside reset only
`define BDEQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("bdeq assertion failed");
// checked on every edge, reset included
`define BDEQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("bdeq assertion failed");
`else
`define BDEQ_ASSERT(lbl, prop)
`define BDEQ_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- hdl/bdeq_pkg.sv -----
// ---------------------------------------------------------------------------
// bdeq_pkg
// Opcodes, status codes, controller states and command struct of the deque.
// ---------------------------------------------------------------------------
package bdeq_pkg;

  localparam int FILL_W = 5;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_BACK   = 2'd2,
    OP_POP_FRONT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_EXEC   = 2'd1,
    S_RESULT = 2'd2
  } state_t;

  typedef struct packed {
    logic load_in;   // capture the input word
    logic exec;      // update ring pointers, write or read the store
    logic load_out;  // move the result into the output register
  } cmd_t;

endpackage

// ----- hdl/bdeq_datapath.sv -----
// ---------------------------------------------------------------------------
// bdeq_datapath
// Ring storage, front pointer, fill count and result register of the deque.
// ---------------------------------------------------------------------------
`include "byte_double_ended_queue_core_defines.svh"

module bdeq_datapath import bdeq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic [1:0]        op,
  input  logic [7:0]        push_value,
  output logic [7:0]        pop_value,
  output logic [1:0]        status,
  output logic [FILL_W-1:0] fill_count
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data;

  op_t           op_r;
  logic [7:0]    value_r;
  logic [IW-1:0] front;
  logic [IW-1:0] front_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  status_t       status_r;
  logic          pop_ok_r;

  logic          is_push;
  logic          ok;
  logic [IW-1:0] front_dec;
  logic [IW-1:0] front_inc;
  logic [IW-1:0] count_lo;
  logic [IW-1:0] count_m1;
  logic [IW-1:0] back_wr_slot;
  logic [IW-1:0] back_rd_slot;
  logic          we;
  logic          re;
  logic [IW-1:0] waddr;
  logic [IW-1:0] raddr;
  status_t       status_now;

  // (front + offset) mod DEPTH; both terms are below DEPTH
  function automatic logic [IW-1:0] ring_slot(input logic [IW-1:0] base,
                                              input logic [IW-1:0] offset);
    logic [IW:0] sum;
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= (IW+1)'(DEPTH)) begin
      sum = sum - (IW+1)'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  always_comb begin
    is_push      = ~op_r[1];
    ok           = is_push ? (count != CW'(DEPTH)) : (count != '0);
    front_dec    = (front == '0) ? IW'(DEPTH - 1) : front - IW'(1);
    front_inc    = (front == IW'(DEPTH - 1)) ? '0 : front + IW'(1);
    count_lo     = count[IW-1:0];
    count_m1     = count_lo - IW'(1);
    back_wr_slot = ring_slot(front, count_lo);
    back_rd_slot = ring_slot(front, count_m1);

    we    = cmd.exec && is_push && ok;
    re    = cmd.exec && !is_push && ok;
    waddr = (op_r == OP_PUSH_BACK) ? back_wr_slot : front_dec;
    raddr = (op_r == OP_POP_BACK) ? back_rd_slot : front;

    front_next = front;
    count_next = count;
    if (cmd.exec && ok) begin
      if (is_push) begin
        count_next = count + CW'(1);
      end else begin
        count_next = count - CW'(1);
      end
      if (op_r == OP_PUSH_FRONT) begin
        front_next = front_dec;
      end else if (op_r == OP_POP_FRONT) begin
        front_next = front_inc;
      end
    end

    if (ok) begin
      status_now = ST_DONE;
    end else if (is_push) begin
      status_now = ST_FULL;
    end else begin
      status_now = ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else begin
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r    <= op_t'(op);
      value_r <= push_value;
    end
    if (cmd.exec) begin
      status_r <= status_now;
      pop_ok_r <= re;
    end
    if (cmd.load_out) begin
      pop_value  <= pop_ok_r ? rd_data : 8'd0;
      status     <= status_r;
      fill_count <= FILL_W'(count);
    end
  end

  `BDEQ_ASSERT(a_count_bound, count <= CW'(DEPTH))
  `BDEQ_ASSERT(a_front_bound, front <= IW'(DEPTH - 1))
  `BDEQ_ASSERT(a_reject_holds, cmd.exec && !ok |=> count == $past(count) && front == $past(front))
  `BDEQ_ASSERT(a_ok_done, cmd.exec && ok |=> status_r == ST_DONE)

endmodule

// ----- hdl/bdeq_ctrl.sv -----
// ---------------------------------------------------------------------------
// bdeq_ctrl
// Sequencer for one deque operation and valid flag of the result register.
// ---------------------------------------------------------------------------
`include "byte_double_ended_queue_core_defines.svh"

module bdeq_ctrl import bdeq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.load_in  = 1'b0;
    cmd.exec     = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
      end
      S_RESULT: begin
        cmd.load_out = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `BDEQ_ASSERT(a_accept_exec, in_valid && in_ready |=> state == S_EXEC)
  `BDEQ_ASSERT(a_exec_result, state == S_EXEC |=> state == S_RESULT)
  `BDEQ_ASSERT(a_result_posted, state == S_RESULT && !out_valid |=> state == S_IDLE && out_valid)
  `BDEQ_ASSERT_ALWAYS(a_reset_clear, rst |=> state == S_IDLE && !out_valid)

endmodule

// ----- hdl/byte_double_ended_queue_core.sv -----
// ---------------------------------------------------------------------------
// byte_double_ended_queue_core
// Bounded deque of bytes in a ring buffer: push or pop at either end.
//
//   channel  direction  handshake             payload
//   in       to core    in_valid / in_ready   op, push_value
//   out      from core  out_valid / out_ready pop_value, status, fill_count
//
// Each word passes through capture, execute (pointer update plus store
// write or registered store read) and result load. A new word is taken once
// the previous one has reached the output register, so a waiting result
// does not block the next word. A stalled output holds the last result and
// the core waits in its result step. Reset clears pointers and fill count;
// the store is not cleared.
// ---------------------------------------------------------------------------
module byte_double_ended_queue_core import bdeq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  input  logic [7:0]        push_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        pop_value,
  output logic [1:0]        status,
  output logic [FILL_W-1:0] fill_count
);

  cmd_t cmd;

  bdeq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bdeq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .op         (op),
    .push_value (push_value),
    .pop_value  (pop_value),
    .status     (status),
    .fill_count (fill_count)
  );

endmodule

// ----- dv/byte_double_ended_queue_core_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// byte_double_ended_queue_core_tb
// Self-checking bench for the byte deque core. A short directed table
// (empty pops, wraparound of the front pointer, full pushes) is followed by
// random phases with shifting push/pop mix, so the queue swings between
// empty and full. Each accepted word runs through a local ring-buffer model
// and the outputs are compared field by field, in order. Both channels
// idle at random; once the output is held off long enough to back up the
// input.
// ---------------------------------------------------------------------------
module byte_double_ended_queue_core_tb import bdeq_pkg::*; ();

  localparam int DEPTH      = 16;
  localparam int RAND_WORDS = 1450;
  localparam int LONG_HOLD  = 400;

  typedef struct packed {
    logic [7:0]        pop;
    status_t           st;
    logic [FILL_W-1:0] fill;
  } deque_result_t;

  typedef struct packed {
    op_t               cmd;
    logic [7:0]        val;
    logic              known;  // expected result typed in below
    logic [7:0]        pop;
    status_t           st;
    logic [FILL_W-1:0] fill;
  } dir_row_t;

  localparam int DIR_ROWS = 26;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{OP_POP_BACK,   8'h00, 1'b1, 8'h00, ST_EMPTY, 5'd0},
    '{OP_POP_FRONT,  8'h5A, 1'b1, 8'h00, ST_EMPTY, 5'd0},
    '{OP_PUSH_BACK,  8'h00, 1'b0, 8'h00, ST_DONE,  5'd0},
    '{OP_PUSH_FRONT, 8'hFF, 1'b0, 8'h00, ST_DONE,  5'd0},
    '{OP_POP_BACK,   8'hFF, 1'b0, 8'h00, ST_DONE,  5'd0},
    '{OP_POP_FRONT,  8'h00, 1'b0, 8'h00, ST_DONE,  5'd0},
    '{OP_PUSH_BACK,  8'h01, 1'b0, 8'h00, ST_DONE,  5'd0},
    '{OP_PUSH_FRONT, 8'h80, 1'b0, 8'h00, ST_DONE,  5'd0},
    '{OP_PUSH_BACK,  8'hFE, 1'b0, 8'h00, ST_DONE,  5'd0},
    '{OP_PUSH_FRONT, 8'h7F, 1'b0, 8'h00, ST_DONE,  5'd0},
    '{OP_PUSH_BACK,  8'hAA, 1'b0, 8'h00, ST_DONE,  5'd0},
    '{OP_PUSH_FRONT, 8'h55, 1'b0, 8'h00, ST_DONE,  5'd0},
    '{OP_PUSH_BACK,  8'h0F, 1'b0, 8'h00, ST_DONE,  5'd0},
    '{OP_PUSH_FRONT, 8'hF0, 1'b0, 8'h00, ST_DONE,  5'd0},
    '{OP_PUSH_BACK,  8'h33, 1'b0, 8'h00, ST_DONE,  5'd0},
    '{OP_PUSH_FRONT, 8'hCC, 1'b0, 8'h00, ST_DONE,  5'd0},
    '{OP_PUSH_BACK,  8'h96, 1'b0, 8'h00, ST_DONE,  5'd0},
    '{OP_PUSH_FRONT, 8'h69, 1'b0, 8'h00, ST_DONE,  5'd0},
    '{OP_PUSH_BACK,  8'h12, 1'b0, 8'h00, ST_DONE,  5'd0},
    '{OP_PUSH_FRONT, 8'hED, 1'b0, 8'h00, ST_DONE,  5'd0},
    '{OP_PUSH_BACK,  8'h3C, 1'b0, 8'h00, ST_DONE,  5'd0},
    '{OP_PUSH_FRONT, 8'hC3, 1'b0, 8'h00, ST_DONE,  5'd0},
    '{OP_PUSH_BACK,  8'hA5, 1'b1, 8'h00, ST_FULL,  5'd16},
    '{OP_PUSH_FRONT, 8'h5A, 1'b1, 8'h00, ST_FULL,  5'd16},
    '{OP_POP_FRONT,  8'h00, 1'b0, 8'h00, ST_DONE,  5'd0},
    '{OP_POP_BACK,   8'hFF, 1'b0, 8'h00, ST_DONE,  5'd0}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        op = OP_PUSH_BACK;
  logic [7:0]        push_value = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        pop_value;
  logic [1:0]        status;
  logic [FILL_W-1:0] fill_count;

  byte_double_ended_queue_core #(.DEPTH(DEPTH)) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .push_value (push_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pop_value  (pop_value),
    .status     (status),
    .fill_count (fill_count)
  );

  always #6 clk = ~clk;

  // ring-buffer model of the deque
  logic [7:0]        ring_mem [DEPTH];
  int unsigned       head_slot = 0;
  logic [FILL_W-1:0] held = '0;

  deque_result_t pending_results [$];
  int            mismatch_count = 0;

  // traffic shaping; switches and hold requests are written by the sequencer with nonblocking assignments
  logic tx_idle_on   = 1'b0;
  logic rx_stalls_on = 1'b0;
  int   holds_asked  = 0;
  int   holds_served = 0;
  int   stall_left   = 0;

  function automatic deque_result_t deque_apply(op_t c, logic [7:0] v);
    deque_result_t r;
    r.pop = 8'h00;
    r.st  = ST_DONE;
    if (c == OP_PUSH_BACK || c == OP_PUSH_FRONT) begin
      if (held >= DEPTH) begin
        r.st = ST_FULL;
      end else if (c == OP_PUSH_BACK) begin
        ring_mem[(head_slot + held) % DEPTH] = v;
        held++;
      end else begin
        head_slot = (head_slot + DEPTH - 1) % DEPTH;
        ring_mem[head_slot] = v;
        held++;
      end
    end else begin
      if (held == 0) begin
        r.st = ST_EMPTY;
      end else if (c == OP_POP_BACK) begin
        r.pop = ring_mem[(head_slot + held - 1) % DEPTH];
        held--;
      end else begin
        r.pop = ring_mem[head_slot];
        head_slot = (head_slot + 1) % DEPTH;
        held--;
      end
    end
    r.fill = held;
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 50);
  endfunction

  // offer one word; returns at the edge where it is taken
  task automatic send_word(input op_t c, input logic [7:0] v, input logic known,
                           input deque_result_t typed);
    int gap;
    deque_result_t got;
    gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= c;
    push_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = deque_apply(c, v);
    pending_results.push_back(known ? typed : got);
  endtask

  // receiver: random stalls plus the requested long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        if (holds_served != holds_asked) begin
          holds_served = holds_asked;
          stall_left   = LONG_HOLD;
        end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
          stall_left = idle_len();
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    deque_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending: pop_value %0h status %0d fill_count %0d",
               pop_value, status, fill_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (pop_value !== want.pop) begin
          $error("pop_value: expected %0h, got %0h", want.pop, pop_value);
          mismatch_count++;
        end
        if (status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status);
          mismatch_count++;
        end
        if (fill_count !== want.fill) begin
          $error("fill_count: expected %0d, got %0d", want.fill, fill_count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    deque_result_t typed;
    int   sent;
    int   phase;
    int   phase_len;
    int   push_pct;
    op_t  c;
    for (int i = 0; i < DEPTH; i++) ring_mem[i] = 8'h00;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      typed.pop  = DIRECTED[i].pop;
      typed.st   = DIRECTED[i].st;
      typed.fill = DIRECTED[i].fill;
      send_word(DIRECTED[i].cmd, DIRECTED[i].val, DIRECTED[i].known, typed);
    end

    sent  = 0;
    phase = 0;
    while (sent < RAND_WORDS) begin
      phase_len = $urandom_range(10, 80);
      case ($urandom_range(0, 4))
        0: push_pct = 10;
        1: push_pct = 40;
        2: push_pct = 50;
        3: push_pct = 60;
        default: push_pct = 90;
      endcase
      if (phase == 2) begin
        // back up the input: no sender gaps while the output is held off
        tx_idle_on   <= 1'b0;
        rx_stalls_on <= 1'b0;
        holds_asked  <= holds_asked + 1;
        phase_len    = 60;
      end else begin
        tx_idle_on   <= ($urandom_range(0, 3) != 0);
        rx_stalls_on <= ($urandom_range(0, 3) != 0);
      end
      for (int k = 0; k < phase_len && sent < RAND_WORDS; k++) begin
        if ($urandom_range(0, 99) < push_pct)
          c = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        else
          c = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        send_word(c, 8'($urandom_range(0, 255)), 1'b0, typed);
        sent++;
      end
      phase++;
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("byte_double_ended_queue_core_tb: PASS");
    else
      $display("byte_double_ended_queue_core_tb: FAIL");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("byte_double_ended_queue_core_tb: FAIL");
    $finish;
  end

endmodule

// ----- byte_double_ended_queue_core.f -----
+incdir+hdl
hdl/bdeq_pkg.sv
hdl/bdeq_datapath.sv
hdl/bdeq_ctrl.sv
hdl/byte_double_ended_queue_core.sv
dv/byte_double_ended_queue_core_tb.sv
